@@ sv/swmf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmf_pkg
// Shared types, constants and side-window helpers for the side-window
// median filter.
// ----------------------------------------------------------------------------
package swmf_pkg;

   localparam int PIX_W          = 8;
   localparam int IMG_W_W        = 11;
   localparam int IMG_H_W        = 13;
   localparam int CSR_DATA_W     = 13;
   localparam int RADIUS_DEF     = 1;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int NUM_SIDES      = 8;
   localparam int DIST_NONE      = 256;

   localparam logic [IMG_W_W-1:0] IMG_W_RESET = 11'd640;
   localparam logic [IMG_H_W-1:0] IMG_H_RESET = 13'd480;

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // side order: NW, NE, SW, SE, up, down, right, left
   function automatic logic side_has(input int side, input int dr, input int dc);
      logic hit;
      begin
         unique case (side)
            0: hit = (dr <= 0) && (dc <= 0);
            1: hit = (dr <= 0) && (dc >= 0);
            2: hit = (dr >= 0) && (dc <= 0);
            3: hit = (dr >= 0) && (dc >= 0);
            4: hit = (dr <= 0);
            5: hit = (dr >= 0);
            6: hit = (dc >= 0);
            default: hit = (dc <= 0);
         endcase
         return hit;
      end
   endfunction

   function automatic int side_size(input int side, input int radius);
      int n;
      begin
         if (side < 4) n = (radius + 1) * (radius + 1);
         else          n = (radius + 1) * (2 * radius + 1);
         return n;
      end
   endfunction

endpackage

@@ sv/swmf_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module swmf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/side_window_median_filter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// side_window_median_filter_top
// Streaming side-window median filter for one 8-bit image plane.
// ----------------------------------------------------------------------------
//  channel | dir | ports                                  | content
//  req     | in  | req_tvalid/tready, req_tdata, req_tuser| pixel_in, flush
//  rsp     | out | rsp_tvalid/tready, rsp_tdata, rsp_tlast| pixel_out, frame_end
//  csr     | in  | csr_we, csr_addr, csr_wdata            | image_width/height
//
//  One item per clock sustained while the output is not stalled. Results
//  leave through RAM read, column update, compare matrix, rank/median and
//  pick. The column store is one RAM, read once per item and written once
//  per pixel item; a write and a read of the same column in adjacent items
//  are covered by a forward path. Reset (synchronous) clears counters, stage
//  valids and size registers, not the store. A stalled output freezes the
//  whole pipe, so req_tready equals "output register free or being taken".
// ----------------------------------------------------------------------------
module side_window_median_filter_top
   import swmf_pkg::*;
#(
   parameter int RADIUS    = RADIUS_DEF,
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIX_W-1:0]      req_tdata,   // [7:0] pixel_in
   input  logic                  req_tuser,   // [0] flush
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PIX_W-1:0]      rsp_tdata,   // [7:0] pixel_out
   output logic                  rsp_tlast,   // frame_end
   input  logic                  csr_we,
   input  logic [0:0]            csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SPAN = 2 * RADIUS + 1;
   localparam int NEL  = SPAN * SPAN;
   localparam int CW   = $clog2(MAX_WIDTH);
   localparam int WW   = CW + 1;
   localparam int RW   = IMG_H_W + 1;
   localparam int VW   = $clog2(SPAN);
   localparam int DW   = PIX_W * SPAN;
   localparam int LW   = $clog2(RADIUS * (MAX_WIDTH + 1) + 2);
   localparam int KW   = $clog2(NEL + 1);

   // ---------------- configuration ----------------
   logic [IMG_W_W-1:0] img_w_ff;
   logic [IMG_H_W-1:0] img_h_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff <= IMG_W_RESET;
         img_h_ff <= IMG_H_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_IMAGE_WIDTH:  img_w_ff <= csr_wdata[IMG_W_W-1:0];
            CSR_IMAGE_HEIGHT: img_h_ff <= csr_wdata[IMG_H_W-1:0];
            default: ;
         endcase
      end
   end

   logic [WW-1:0]      w_eff;
   logic [IMG_H_W-1:0] h_eff;
   logic [31:0]        w_raw;

   assign w_raw = 32'(img_w_ff);
   assign w_eff = WW'((w_raw == 32'd0) ? 32'd1 :
                      ((w_raw > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : w_raw));
   assign h_eff = (img_h_ff == '0) ? IMG_H_W'(1) : img_h_ff;

   // ---------------- pipe control ----------------
   logic rsp_valid_ff;
   logic en;
   logic acc;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign acc        = req_tvalid && en;

   // ---------------- position counters ----------------
   logic [CW-1:0]      in_col_ff,  in_col_in;
   logic [IMG_H_W-1:0] in_row_ff,  in_row_in;
   logic [CW-1:0]      out_col_ff, out_col_in;
   logic [IMG_H_W-1:0] out_row_ff, out_row_in;
   logic [LW-1:0]      lag_ff,     lag_in;

   logic          done, wr, emit, last, interior;
   logic [LW-1:0] thr;
   logic          in_col_end, out_col_end;
   logic [VW-1:0] vidx;
   logic [CW-1:0] rd_addr;

   always_comb begin
      done        = (in_row_ff >= h_eff);
      wr          = acc && !req_tuser && !done;
      thr         = LW'(RADIUS * 32'(w_eff) + RADIUS);
      emit        = acc && (wr ? (lag_ff >= thr) : done);
      in_col_end  = (WW'(in_col_ff) + WW'(1)) >= w_eff;
      out_col_end = (WW'(out_col_ff) + WW'(1)) >= w_eff;
      last        = out_col_end && ((RW'(out_row_ff) + RW'(1)) >= RW'(h_eff));
      interior    = (RW'(out_row_ff) >= RW'(RADIUS)) &&
                    ((RW'(out_row_ff) + RW'(RADIUS)) < RW'(h_eff)) &&
                    (WW'(out_col_ff) >= WW'(RADIUS)) &&
                    ((WW'(out_col_ff) + WW'(RADIUS)) < w_eff);
      // row of out_row inside the drained column: newest row sits at 0
      vidx        = VW'(h_eff - IMG_H_W'(1) - out_row_ff);
      rd_addr     = wr ? in_col_ff : out_col_ff;

      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      lag_in     = lag_ff;
      if (wr) begin
         lag_in = lag_ff + LW'(1);
         if (in_col_end) begin
            in_col_in = '0;
            in_row_in = in_row_ff + IMG_H_W'(1);
         end else begin
            in_col_in = in_col_ff + CW'(1);
         end
      end
      if (emit) begin
         lag_in = lag_in - LW'(1);
         if (last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
            lag_in     = '0;
         end else if (out_col_end) begin
            out_col_in = '0;
            out_row_in = out_row_ff + IMG_H_W'(1);
         end else begin
            out_col_in = out_col_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         lag_ff     <= '0;
      end else begin
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         lag_ff     <= lag_in;
      end
   end

   // ---------------- stage 1: column store read/modify/write ----------------
   // Each RAM word holds the newest SPAN pixels of one column, newest low.
   logic             s1_valid_ff, s1_wr_ff, s1_emit_ff, s1_int_ff, s1_last_ff;
   logic [PIX_W-1:0] s1_pix_ff;
   logic [CW-1:0]    s1_addr_ff;
   logic [VW-1:0]    s1_vidx_ff;
   logic             fwd_hit_ff;
   logic [DW-1:0]    fwd_data_ff;
   logic [DW-1:0]    ram_q, col, new_col;
   logic             ram_we, fwd_hit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= wr || emit;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_wr_ff    <= wr;
         s1_emit_ff  <= emit;
         s1_int_ff   <= interior;
         s1_last_ff  <= last;
         s1_pix_ff   <= req_tdata;
         s1_addr_ff  <= rd_addr;
         s1_vidx_ff  <= vidx;
         fwd_hit_ff  <= fwd_hit_in;
         fwd_data_ff <= new_col;
      end
   end

   assign col        = fwd_hit_ff ? fwd_data_ff : ram_q;
   assign new_col    = {col[DW-PIX_W-1:0], s1_pix_ff};
   assign ram_we     = en && s1_valid_ff && s1_wr_ff;
   // same column read in the cycle it is written: RAM returns old word
   assign fwd_hit_in = s1_valid_ff && s1_wr_ff && (s1_addr_ff == rd_addr);

   swmf_ram #(
      .WIDTH (DW),
      .DEPTH (MAX_WIDTH)
   ) u_col_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_addr_ff),
      .wr_data (new_col),
      .rd_en   (en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // window: slot 0 is the newest column; slot RADIUS holds the centre column
   logic [DW-1:0] win_ff [SPAN];

   always_ff @(posedge clock) begin
      if (ram_we) begin
         win_ff[0] <= new_col;
         for (int k = 1; k < SPAN; k++) begin
            win_ff[k] <= win_ff[k-1];
         end
      end
   end

   // ---------------- stage 2: compare matrix ----------------
   logic             s2_valid_ff, s2_drain_ff, s2_int_ff, s2_last_ff;
   logic [PIX_W-1:0] s2_cdrain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_drain_ff  <= !s1_wr_ff;
         s2_int_ff    <= s1_int_ff;
         s2_last_ff   <= s1_last_ff;
         s2_cdrain_ff <= col[s1_vidx_ff*PIX_W +: PIX_W];
      end
   end

   logic [PIX_W-1:0] s2_x [NEL];
   logic [NEL-1:0]   s2_lt [NEL];
   logic [PIX_W-1:0] s2_centre;

   // element e = slot*SPAN + vertical; lt[e][j]: j orders before e
   always_comb begin
      for (int e = 0; e < NEL; e++) begin
         s2_x[e] = win_ff[e / SPAN][(e % SPAN)*PIX_W +: PIX_W];
      end
      for (int e = 0; e < NEL; e++) begin
         for (int j = 0; j < NEL; j++) begin
            s2_lt[e][j] = (s2_x[j] < s2_x[e]) || ((s2_x[j] == s2_x[e]) && (j < e));
         end
      end
      s2_centre = s2_drain_ff ? s2_cdrain_ff : win_ff[RADIUS][RADIUS*PIX_W +: PIX_W];
   end

   // ---------------- stage 3: ranks and side medians ----------------
   logic             s3_valid_ff, s3_int_ff, s3_last_ff;
   logic [PIX_W-1:0] s3_centre_ff;
   logic [PIX_W-1:0] s3_x_ff [NEL];
   logic [NEL-1:0]   s3_lt_ff [NEL];

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_int_ff    <= s2_int_ff;
         s3_last_ff   <= s2_last_ff;
         s3_centre_ff <= s2_centre;
         s3_x_ff      <= s2_x;
         s3_lt_ff     <= s2_lt;
      end
   end

   logic [PIX_W-1:0] s3_med [NUM_SIDES];

   always_comb begin
      logic [KW-1:0] rank;
      logic          mem_e;
      for (int s = 0; s < NUM_SIDES; s++) begin
         s3_med[s] = '0;
         for (int e = 0; e < NEL; e++) begin
            rank  = '0;
            mem_e = side_has(s, RADIUS - (e % SPAN), RADIUS - (e / SPAN));
            for (int j = 0; j < NEL; j++) begin
               if (side_has(s, RADIUS - (j % SPAN), RADIUS - (j / SPAN))) begin
                  rank = rank + KW'(s3_lt_ff[e][j]);
               end
            end
            if (mem_e && (rank == KW'(side_size(s, RADIUS) / 2))) begin
               s3_med[s] = s3_x_ff[e];
            end
         end
      end
   end

   // ---------------- stage 4: closest median ----------------
   logic             s4_valid_ff, s4_int_ff, s4_last_ff;
   logic [PIX_W-1:0] s4_centre_ff;
   logic [PIX_W-1:0] s4_med_ff [NUM_SIDES];

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_int_ff    <= s3_int_ff;
         s4_last_ff   <= s3_last_ff;
         s4_centre_ff <= s3_centre_ff;
         s4_med_ff    <= s3_med;
      end
   end

   logic [PIX_W-1:0] pick;

   // strict compare: earliest side wins a tie
   always_comb begin
      logic [PIX_W:0] best;
      logic [PIX_W:0] d;
      best = (PIX_W+1)'(DIST_NONE);
      pick = s4_centre_ff;
      for (int s = 0; s < NUM_SIDES; s++) begin
         d = (s4_med_ff[s] >= s4_centre_ff) ?
             (PIX_W+1)'(s4_med_ff[s] - s4_centre_ff) :
             (PIX_W+1)'(s4_centre_ff - s4_med_ff[s]);
         if (d < best) begin
            best = d;
            pick = s4_med_ff[s];
         end
      end
      if (!s4_int_ff) begin
         pick = s4_centre_ff;
      end
   end

   // ---------------- output register ----------------
   logic [PIX_W-1:0] rsp_data_ff;
   logic             rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= pick;
         rsp_last_ff <= s4_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ sv/swmf_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmf_checker
// Port-level checks of the side-window median filter, bound to the top.
// ----------------------------------------------------------------------------
module swmf_checker
   import swmf_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [PIX_W-1:0] rsp_tdata,
   input logic             rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp item changed while stalled");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input stalled while output free");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result after reset");

   // free-running cycles with no input, as many as the pipe has stage registers, flush the whole pipe
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid &&
      !$past(req_tvalid, 1) && !$past(req_tvalid, 2) && !$past(req_tvalid, 3) &&
      !$past(req_tvalid, 4) && !$past(req_tvalid, 5) &&
      $past(req_tready, 1) && $past(req_tready, 2) && $past(req_tready, 3) &&
      $past(req_tready, 4) && $past(req_tready, 5) |=> !rsp_tvalid)
      else $error("result without an item");

endmodule

bind side_window_median_filter_top swmf_checker u_swmf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the side-window median filter. Frames of
// assorted sizes are streamed in, with random gaps, stalls and noise items.
// Every accepted result is checked against a behavioral predictor or a typed table.
// ----------------------------------------------------------------------------
module tb_top;
   import swmf_pkg::*;

   localparam int RAD   = RADIUS_DEF;
   localparam int MAXW  = MAX_WIDTH_DEF;
   localparam int SPAN  = 2 * RAD + 1;

   typedef enum logic [1:0] {
      EXP_NONE,   // row causes no result
      EXP_TYPED,  // result typed into the table
      EXP_PRED    // result taken from the predictor
   } exp_kind_type;

   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic             flush;
      exp_kind_type     kind;
      logic [PIX_W-1:0] exp_pix;
      logic             exp_last;
   } stim_row_type;

   typedef struct packed {
      logic [PIX_W-1:0] pix;
      logic             last;
   } filtered_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [PIX_W-1:0]      rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_we;
   logic [0:0]            csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   side_window_median_filter_top u_top (.*);

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ---- predictor state ----------------------------------------------------
   logic [PIX_W-1:0]   line_mem [SPAN*MAXW];
   logic [IMG_W_W-1:0] width_reg;
   logic [IMG_H_W-1:0] height_reg;
   int                 in_col, in_row, out_col, out_row;
   bit                 frame_closed;

   filtered_type       expected_q[$];
   int                 mismatches;
   int                 idle_pct;     // sender gap chance
   int                 stall_pct;    // receiver stall chance
   bit                 hold_now;     // one-shot request for a long back-pressure

   function automatic int eff_width();
      int w;
      w = width_reg;
      if (w == 0) w = 1;
      if (w > MAXW) w = MAXW;
      return w;
   endfunction

   function automatic int eff_height();
      return (height_reg == 0) ? 1 : int'(height_reg);
   endfunction

   function automatic logic [PIX_W-1:0] store_at(int row, int col);
      if (col < 0 || col >= MAXW) return '0;
      return line_mem[(row % SPAN) * MAXW + col];
   endfunction

   // NW, NE, SW, SE quadrants, then up, down, right, left halves
   function automatic bit side_in(int side, int dr, int dc);
      case (side)
         0: return dr <= 0 && dc <= 0;
         1: return dr <= 0 && dc >= 0;
         2: return dr >= 0 && dc <= 0;
         3: return dr >= 0 && dc >= 0;
         4: return dr <= 0;
         5: return dr >= 0;
         6: return dc >= 0;
         default: return dc <= 0;
      endcase
   endfunction

   // median of one side window (element n/2 after sorting)
   function automatic logic [PIX_W-1:0] side_median_of(int side, int row, int col);
      logic [PIX_W-1:0] vals [SPAN*SPAN];
      logic [PIX_W-1:0] x;
      int               n;
      int               i;
      n = 0;
      for (int dr = -RAD; dr <= RAD; dr++) begin
         for (int dc = -RAD; dc <= RAD; dc++) begin
            if (!side_in(side, dr, dc)) continue;
            x = store_at(row + dr, col + dc);
            i = n;
            n++;
            while (i > 0 && vals[i-1] > x) begin
               vals[i] = vals[i-1];
               i--;
            end
            vals[i] = x;
         end
      end
      return vals[n/2];
   endfunction

   function automatic logic [PIX_W-1:0] filter_pixel(int row, int col, int w, int h);
      logic [PIX_W-1:0] centre;
      logic [PIX_W-1:0] pick;
      logic [PIX_W-1:0] m;
      int               best;
      int               d;
      centre = store_at(row, col);
      if (row < RAD || row + RAD >= h || col < RAD || col + RAD >= w) return centre;
      best = DIST_NONE;
      pick = centre;
      for (int k = 0; k < NUM_SIDES; k++) begin
         m = side_median_of(k, row, col);
         d = int'(m) - int'(centre);
         if (d < 0) d = -d;
         if (d < best) begin     // strict: earlier window wins a tie
            best = d;
            pick = m;
         end
      end
      return pick;
   endfunction

   // advance the predictor by one accepted item
   task automatic predict_pixel(input logic [PIX_W-1:0] pix, input logic flush,
                                output bit emit, output filtered_type res);
      int      w;
      int      h;
      longint  p;
      longint  o;
      bit      done;
      w = eff_width();
      h = eff_height();
      done = (in_row >= h);
      res = '0;
      if (!flush && !done) begin
         if (in_col < MAXW) line_mem[(in_row % SPAN) * MAXW + in_col] = pix;
         p = longint'(in_row) * w + in_col;
         if (in_col + 1 >= w) begin
            in_col = 0;
            in_row++;
         end else begin
            in_col++;
         end
         o = longint'(out_row) * w + out_col;
         emit = (p >= o + longint'(RAD) * w + RAD);
      end else begin
         emit = done;
      end
      if (!emit) return;
      res.pix  = filter_pixel(out_row, out_col, w, h);
      res.last = (out_col + 1 >= w) && (out_row + 1 >= h);
      if (res.last) begin
         in_col = 0; in_row = 0; out_col = 0; out_row = 0;
         frame_closed = 1'b1;
      end else if (out_col + 1 >= w) begin
         out_col = 0;
         out_row++;
      end else begin
         out_col++;
      end
   endtask

   // ---- drivers --------------------------------------------------------------
   // one item: random gaps first, then hold valid until taken; valid stays
   // up on return so back-to-back items need no extra edge
   task automatic send_item(input logic [PIX_W-1:0] pix, input logic flush,
                            input exp_kind_type kind, input filtered_type typed);
      bit           emit;
      filtered_type res;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= PIX_W'($urandom);
         req_tuser  <= 1'($urandom);
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tuser  <= flush;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_pixel(pix, flush, emit, res);
      if (kind == EXP_TYPED) expected_q = {expected_q, typed};
      else if (kind == EXP_PRED && emit) expected_q = {expected_q, res};
      @(negedge clock);
   endtask

   // register write, only once the block has drained
   task automatic write_csr(input csr_index_type idx, input int value);
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);   // covers the pipe after no-result items
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_we    <= 1'b0;
      if (idx == CSR_IMAGE_WIDTH) width_reg  = IMG_W_W'(value);
      else                        height_reg = IMG_H_W'(value);
   endtask

   // a whole frame: pixels with some mid-frame flush noise, then drain items
   task automatic run_frame(input int noise_pct);
      int n;
      n = eff_width() * eff_height();
      frame_closed = 1'b0;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < noise_pct)
            send_item(PIX_W'($urandom), 1'b1, EXP_PRED, '0);
         if (!frame_closed)
            send_item(PIX_W'($urandom), 1'b0, EXP_PRED, '0);
      end
      // past the end a plain pixel drains just like a flush
      while (!frame_closed)
         send_item(PIX_W'($urandom), 1'($urandom), EXP_PRED, '0);
   endtask

   task automatic set_phase(input int phase);
      case (phase % 4)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 54; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 54; end
         default: begin idle_pct = 29; stall_pct = 29; end
      endcase
   endtask

   // ---- receiver -------------------------------------------------------------
   initial begin
      int hold_left;
      hold_left  = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_now) begin
            hold_now  = 1'b0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // ---- checker ----------------------------------------------------------------
   always @(posedge clock) begin
      filtered_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: pix=%0d last=%0b", rsp_tdata, rsp_tlast);
         end else begin
            want = expected_q.pop_front();
            if (rsp_tdata !== want.pix || rsp_tlast !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp pix=%0d last=%0b, got pix=%0d last=%0b",
                           want.pix, want.last, rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   // ---- directed table -------------------------------------------------------
   // 3x3 frame: only the centre pixel is filtered, the rest pass through.
   // A result appears once the item one row and one pixel further is in.
   stim_row_type dir_rows [14] = '{
      '{8'd77,  1'b1, EXP_NONE,  8'd0,   1'b0},  // flush mid-frame: ignored
      '{8'd0,   1'b0, EXP_NONE,  8'd0,   1'b0},
      '{8'd255, 1'b0, EXP_NONE,  8'd0,   1'b0},
      '{8'd17,  1'b0, EXP_NONE,  8'd0,   1'b0},
      '{8'd128, 1'b0, EXP_NONE,  8'd0,   1'b0},
      '{8'd200, 1'b0, EXP_TYPED, 8'd0,   1'b0},
      '{8'd1,   1'b0, EXP_TYPED, 8'd255, 1'b0},
      '{8'd99,  1'b0, EXP_TYPED, 8'd17,  1'b0},
      '{8'd254, 1'b0, EXP_TYPED, 8'd128, 1'b0},
      '{8'd64,  1'b0, EXP_PRED,  8'd0,   1'b0},  // centre: predictor
      '{8'd0,   1'b1, EXP_TYPED, 8'd1,   1'b0},
      '{8'd170, 1'b0, EXP_TYPED, 8'd99,  1'b0},  // pixel after end is dropped
      '{8'd0,   1'b1, EXP_TYPED, 8'd254, 1'b0},
      '{8'd0,   1'b1, EXP_TYPED, 8'd64,  1'b1}
   };

   // ---- main sequence --------------------------------------------------------
   initial begin
      int sent_frames;
      int random_items;
      int w;
      int h;
      mismatches = 0;
      hold_now   = 1'b0;
      idle_pct   = 0;
      stall_pct  = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = CSR_IMAGE_WIDTH;
      csr_wdata  = '0;
      width_reg  = IMG_W_RESET;
      height_reg = IMG_H_RESET;
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_csr(CSR_IMAGE_WIDTH, 3);
      write_csr(CSR_IMAGE_HEIGHT, 3);
      frame_closed = 1'b0;
      foreach (dir_rows[i])
         send_item(dir_rows[i].pix, dir_rows[i].flush, dir_rows[i].kind,
                   {dir_rows[i].exp_pix, dir_rows[i].exp_last});

      // size extremes: zero sizes act as one
      write_csr(CSR_IMAGE_WIDTH, 0);
      write_csr(CSR_IMAGE_HEIGHT, 0);
      run_frame(5);
      write_csr(CSR_IMAGE_WIDTH, 1);
      write_csr(CSR_IMAGE_HEIGHT, 1);
      run_frame(5);

      // long receiver hold while the sender keeps pushing
      write_csr(CSR_IMAGE_WIDTH, 16);
      write_csr(CSR_IMAGE_HEIGHT, 4);
      set_phase(0);
      hold_now = 1'b1;
      run_frame(0);

      // random frames, mostly small, cycling through gap and stall phases
      sent_frames  = 0;
      random_items = 0;
      while (random_items < 880) begin
         set_phase(sent_frames);
         w = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 24);
         h = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
         write_csr(CSR_IMAGE_WIDTH, w);
         write_csr(CSR_IMAGE_HEIGHT, h);
         run_frame(5);
         random_items += w * h;
         sent_frames++;
      end

      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // leftover expectations at the end hang the drain wait above; this timeout catches them
   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

@@ side_window_median_filter_top.f @@
sv/swmf_pkg.sv
sv/swmf_ram.sv
sv/side_window_median_filter_top.sv
sv/swmf_checker.sv
tb/tb_top.sv
